FILE: rtl/core/cf3_pkg.sv
// Shared constants, types and step program of the circle-from-linear-system block.
`default_nettype none
package cf3_pkg;

  localparam int DATA_WIDTH_DEF = 48;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int QDEPTH         = 2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_PIVOT = 2'd1;
  localparam logic [1:0] ST_NEG   = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  // Step operations.
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CHKZ = 3'd4;
  localparam logic [2:0] OP_SQRT = 3'd5;

  // Working register indexes.
  localparam logic [4:0] RI_A00  = 5'd0;
  localparam logic [4:0] RI_A01  = 5'd1;
  localparam logic [4:0] RI_A02  = 5'd2;
  localparam logic [4:0] RI_A10  = 5'd3;
  localparam logic [4:0] RI_A11  = 5'd4;
  localparam logic [4:0] RI_A12  = 5'd5;
  localparam logic [4:0] RI_A20  = 5'd6;
  localparam logic [4:0] RI_A21  = 5'd7;
  localparam logic [4:0] RI_A22  = 5'd8;
  localparam logic [4:0] RI_B0   = 5'd9;
  localparam logic [4:0] RI_B1   = 5'd10;
  localparam logic [4:0] RI_B2   = 5'd11;
  localparam logic [4:0] RI_F    = 5'd12;
  localparam logic [4:0] RI_T    = 5'd13;
  localparam logic [4:0] RI_U    = 5'd14;
  localparam logic [4:0] RI_X2   = 5'd15;
  localparam logic [4:0] RI_X1   = 5'd16;
  localparam logic [4:0] RI_CX   = 5'd17;
  localparam logic [4:0] RI_CY   = 5'd18;
  localparam logic [4:0] RI_ZERO = 5'd19;
  localparam int         NREG    = 19;
  localparam int         NIN     = 12;

  localparam logic [5:0] PC_LAST = 6'd36;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] sa;
    logic [4:0] sb;
    logic [4:0] dst;
  } cf3_uop_t;

  // Handshake and classification from the front queue to the back end.
  typedef struct packed {
    logic vld;
    logic a00_zero;
  } cf3_hs_t;

  function automatic cf3_uop_t ucode(input logic [5:0] pc);
    cf3_uop_t u;
    case (pc)
      6'd0:  u = '{OP_DIV,  RI_A10,  RI_A00, RI_F};
      6'd1:  u = '{OP_MUL,  RI_F,    RI_A01, RI_T};
      6'd2:  u = '{OP_SUB,  RI_A11,  RI_T,   RI_A11};
      6'd3:  u = '{OP_MUL,  RI_F,    RI_A02, RI_T};
      6'd4:  u = '{OP_SUB,  RI_A12,  RI_T,   RI_A12};
      6'd5:  u = '{OP_MUL,  RI_F,    RI_B0,  RI_T};
      6'd6:  u = '{OP_SUB,  RI_B1,   RI_T,   RI_B1};
      6'd7:  u = '{OP_DIV,  RI_A20,  RI_A00, RI_F};
      6'd8:  u = '{OP_MUL,  RI_F,    RI_A01, RI_T};
      6'd9:  u = '{OP_SUB,  RI_A21,  RI_T,   RI_A21};
      6'd10: u = '{OP_MUL,  RI_F,    RI_A02, RI_T};
      6'd11: u = '{OP_SUB,  RI_A22,  RI_T,   RI_A22};
      6'd12: u = '{OP_MUL,  RI_F,    RI_B0,  RI_T};
      6'd13: u = '{OP_SUB,  RI_B2,   RI_T,   RI_B2};
      6'd14: u = '{OP_CHKZ, RI_A11,  RI_A11, RI_T};
      6'd15: u = '{OP_DIV,  RI_A21,  RI_A11, RI_F};
      6'd16: u = '{OP_MUL,  RI_F,    RI_A12, RI_T};
      6'd17: u = '{OP_SUB,  RI_A22,  RI_T,   RI_A22};
      6'd18: u = '{OP_MUL,  RI_F,    RI_B1,  RI_T};
      6'd19: u = '{OP_SUB,  RI_B2,   RI_T,   RI_B2};
      6'd20: u = '{OP_CHKZ, RI_A22,  RI_A22, RI_T};
      6'd21: u = '{OP_DIV,  RI_B2,   RI_A22, RI_X2};
      6'd22: u = '{OP_MUL,  RI_X2,   RI_A12, RI_T};
      6'd23: u = '{OP_SUB,  RI_B1,   RI_T,   RI_T};
      6'd24: u = '{OP_DIV,  RI_T,    RI_A11, RI_X1};
      6'd25: u = '{OP_MUL,  RI_X2,   RI_A02, RI_T};
      6'd26: u = '{OP_SUB,  RI_B0,   RI_T,   RI_U};
      6'd27: u = '{OP_MUL,  RI_X1,   RI_A01, RI_T};
      6'd28: u = '{OP_SUB,  RI_U,    RI_T,   RI_U};
      6'd29: u = '{OP_DIV,  RI_U,    RI_A00, RI_F};
      6'd30: u = '{OP_SUB,  RI_ZERO, RI_F,   RI_CX};
      6'd31: u = '{OP_SUB,  RI_ZERO, RI_X1,  RI_CY};
      6'd32: u = '{OP_MUL,  RI_CX,   RI_CX,  RI_T};
      6'd33: u = '{OP_MUL,  RI_CY,   RI_CY,  RI_U};
      6'd34: u = '{OP_ADD,  RI_T,    RI_U,   RI_T};
      6'd35: u = '{OP_SUB,  RI_T,    RI_X2,  RI_T};
      default: u = '{OP_SQRT, RI_T,  RI_T,   RI_T};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cf3_front.sv
// Input side: accepts systems, flags a zero leading pivot and queues them for the back end.
`default_nettype none
module cf3_front
  import cf3_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [NIN*DATA_WIDTH-1:0]    sys_i,
  output cf3_hs_t                           hs_o,
  output logic [NIN*DATA_WIDTH-1:0]         sys_o,
  input  wire logic                         take
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);
  localparam logic [QCW-1:0] QFULL = QCW'(QDEPTH);
  localparam logic [QAW-1:0] QLAST = QAW'(QDEPTH - 1);

  logic [NIN*DATA_WIDTH-1:0] data_r [QDEPTH];
  logic                      zflag_r [QDEPTH];
  logic [QAW-1:0]            wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCW-1:0]            cnt_r, cnt_nxt;
  logic                      wr, rd;

  assign full  = (cnt_r == QFULL);
  assign wr    = push && !full;
  assign rd    = take && (cnt_r != '0);
  assign hs_o  = '{vld: (cnt_r != '0), a00_zero: zflag_r[rp_r]};
  assign sys_o = data_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr) begin
      wp_nxt = (wp_r == QLAST) ? '0 : wp_r + 1'b1;
    end
    if (rd) begin
      rp_nxt = (rp_r == QLAST) ? '0 : rp_r + 1'b1;
    end
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      data_r[wp_r]  <= sys_i;
      zflag_r[wp_r] <= (sys_i[DATA_WIDTH-1:0] == '0);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/cf3_back.sv
// Back end: step sequencer with shared multiplier, divider and square-root units.
`default_nettype none
module cf3_back
  import cf3_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  cf3_hs_t                           hs_i,
  input  wire logic [NIN*DATA_WIDTH-1:0]    sys_i,
  output logic                              take,
  output logic                              empty,
  input  wire logic                         pop,
  output logic signed [DATA_WIDTH-1:0]      center_x,
  output logic signed [DATA_WIDTH-1:0]      center_y,
  output logic [DATA_WIDTH-2:0]             radius,
  output logic [1:0]                        status
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DW  = W + F;
  localparam int SQ  = (W + F + 1) / 2;
  localparam int MW  = (2 * W > DW) ? 2 * W : DW;
  localparam int CW  = $clog2(DW + 1);
  localparam int RIW = $clog2(NREG);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_ITER  = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]          st_r, st_nxt;
  logic [5:0]          pc_r, pc_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                sat_r, sat_nxt;
  logic [W-1:0]        rf_r [NREG];
  logic [W-1:0]        opa_r, opb_r;
  logic [W-1:0]        ma_r, ma_nxt;
  logic [2*W:0]        pr_r, pr_nxt;
  logic                neg_r, neg_nxt;
  logic [W-1:0]        dv_r, dv_nxt, rm_r, rm_nxt;
  logic [DW-1:0]       nq_r, nq_nxt;
  logic [SQ:0]         srem_r, srem_nxt;
  logic [SQ-1:0]       root_r, root_nxt;
  logic [2*SQ-1:0]     srn_r, srn_nxt;
  logic [W-1:0]        ocx_r, ocx_nxt, ocy_r, ocy_nxt;
  logic [W-2:0]        orad_r, orad_nxt;
  logic [1:0]          ost_r, ost_nxt;

  cf3_uop_t            uop;
  logic                rf_we;
  logic [4:0]          rf_wi;
  logic [W-1:0]        rf_wd;
  logic                load;

  logic [W:0]          as_res;
  logic [W:0]          fm_res;
  logic [MW-1:0]       fm_mag;
  logic [W:0]          mul_sum;
  logic [W+1:0]        div_tv;
  logic [SQ+2:0]       sq_sh;
  logic [SQ+3:0]       sq_tv;
  logic [SQ+W-1:0]     root_ext;
  logic [SQ+W-1:0]     root_lim;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // Saturating add or subtract; the top bit of the result flags saturation.
  function automatic logic [W:0] sat_as(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input logic sub);
    logic [W:0] s;
    logic [W:0] r;
    s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    if (s[W] != s[W-1]) begin
      r = {1'b1, s[W], {(W-1){~s[W]}}};
    end else begin
      r = {1'b0, s[W-1:0]};
    end
    return r;
  endfunction

  // Signed value from sign and magnitude, clamped to the word range.
  function automatic logic [W:0] from_mag(input logic neg, input logic [MW-1:0] m);
    logic [MW-1:0] lim;
    logic [W-1:0]  v;
    logic          s;
    lim = {{(MW-W){1'b0}}, neg, {(W-1){~neg}}};
    s   = (m > lim);
    v   = s ? lim[W-1:0] : m[W-1:0];
    return {s, neg ? (~v + 1'b1) : v};
  endfunction

  assign uop      = ucode(pc_r);
  assign take     = (st_r == S_IDLE) && hs_i.vld;
  assign load     = take;
  assign empty    = (st_r != S_OUT);
  assign center_x = ocx_r;
  assign center_y = ocy_r;
  assign radius   = orad_r;
  assign status   = ost_r;

  assign as_res   = sat_as(opa_r, opb_r, uop.op == OP_SUB);
  assign fm_mag   = (uop.op == OP_MUL) ? MW'(pr_r[2*W-1:F]) : MW'(nq_r);
  assign fm_res   = from_mag(neg_r, fm_mag);
  assign mul_sum  = pr_r[2*W:W] + {1'b0, ma_r};
  assign div_tv   = {1'b0, rm_r, nq_r[DW-1]} - {2'b00, dv_r};
  assign sq_sh    = {srem_r, srn_r[2*SQ-1:2*SQ-2]};
  assign sq_tv    = {1'b0, sq_sh} - {2'b00, root_r, 2'b01};
  assign root_ext = (SQ+W)'(root_r);
  assign root_lim = {{(SQ+1){1'b0}}, {(W-1){1'b1}}};

  always_comb begin
    st_nxt   = st_r;
    pc_nxt   = pc_r;
    cnt_nxt  = cnt_r;
    sat_nxt  = sat_r;
    ma_nxt   = ma_r;
    pr_nxt   = pr_r;
    neg_nxt  = neg_r;
    dv_nxt   = dv_r;
    rm_nxt   = rm_r;
    nq_nxt   = nq_r;
    srem_nxt = srem_r;
    root_nxt = root_r;
    srn_nxt  = srn_r;
    ocx_nxt  = ocx_r;
    ocy_nxt  = ocy_r;
    orad_nxt = orad_r;
    ost_nxt  = ost_r;
    rf_we    = 1'b0;
    rf_wi    = uop.dst;
    rf_wd    = as_res[W-1:0];
    case (st_r)
      S_IDLE: begin
        if (hs_i.vld) begin
          sat_nxt = 1'b0;
          pc_nxt  = '0;
          if (hs_i.a00_zero) begin
            ocx_nxt  = '0;
            ocy_nxt  = '0;
            orad_nxt = '0;
            ost_nxt  = ST_PIVOT;
            st_nxt   = S_OUT;
          end else begin
            st_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        st_nxt = S_SETUP;
      end
      S_SETUP: begin
        case (uop.op)
          OP_ADD, OP_SUB: begin
            rf_we   = 1'b1;
            sat_nxt = sat_r | as_res[W];
            pc_nxt  = pc_r + 1'b1;
            st_nxt  = S_FETCH;
          end
          OP_MUL: begin
            ma_nxt  = mag(opa_r);
            pr_nxt  = {{(W+1){1'b0}}, mag(opb_r)};
            neg_nxt = opa_r[W-1] ^ opb_r[W-1];
            cnt_nxt = CW'(W - 1);
            st_nxt  = S_ITER;
          end
          OP_DIV: begin
            nq_nxt  = {mag(opa_r), {F{1'b0}}};
            dv_nxt  = mag(opb_r);
            rm_nxt  = '0;
            neg_nxt = opa_r[W-1] ^ opb_r[W-1];
            cnt_nxt = CW'(DW - 1);
            st_nxt  = S_ITER;
          end
          OP_CHKZ: begin
            if (opa_r == '0) begin
              ocx_nxt  = '0;
              ocy_nxt  = '0;
              orad_nxt = '0;
              ost_nxt  = ST_PIVOT;
              st_nxt   = S_OUT;
            end else begin
              pc_nxt = pc_r + 1'b1;
              st_nxt = S_FETCH;
            end
          end
          default: begin
            ocx_nxt = rf_r[RI_CX[RIW-1:0]];
            ocy_nxt = rf_r[RI_CY[RIW-1:0]];
            if (opa_r[W-1]) begin
              orad_nxt = '0;
              ost_nxt  = ST_NEG;
              st_nxt   = S_OUT;
            end else begin
              srn_nxt  = {{(2*SQ-W+1-F){1'b0}}, opa_r[W-2:0], {F{1'b0}}};
              srem_nxt = '0;
              root_nxt = '0;
              cnt_nxt  = CW'(SQ - 1);
              st_nxt   = S_ITER;
            end
          end
        endcase
      end
      S_ITER: begin
        case (uop.op)
          OP_MUL: begin
            pr_nxt = {1'b0, (pr_r[0] ? mul_sum : pr_r[2*W:W]), pr_r[W-1:1]};
          end
          OP_DIV: begin
            rm_nxt = div_tv[W+1] ? {rm_r[W-2:0], nq_r[DW-1]} : div_tv[W-1:0];
            nq_nxt = {nq_r[DW-2:0], ~div_tv[W+1]};
          end
          default: begin
            srn_nxt = {srn_r[2*SQ-3:0], 2'b00};
            if (!sq_tv[SQ+3]) begin
              srem_nxt = sq_tv[SQ:0];
              root_nxt = {root_r[SQ-2:0], 1'b1};
            end else begin
              srem_nxt = sq_sh[SQ:0];
              root_nxt = {root_r[SQ-2:0], 1'b0};
            end
          end
        endcase
        if (cnt_r == '0) begin
          st_nxt = S_WB;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_WB: begin
        if (uop.op == OP_SQRT) begin
          if (root_ext > root_lim) begin
            orad_nxt = '1;
            ost_nxt  = ST_SAT;
          end else begin
            orad_nxt = root_ext[W-2:0];
            ost_nxt  = sat_r ? ST_SAT : ST_OK;
          end
          st_nxt = S_OUT;
        end else begin
          rf_we   = 1'b1;
          rf_wd   = fm_res[W-1:0];
          sat_nxt = sat_r | fm_res[W];
          pc_nxt  = pc_r + 1'b1;
          st_nxt  = S_FETCH;
        end
      end
      S_OUT: begin
        if (pop) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      pc_r  <= '0;
      cnt_r <= '0;
      sat_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
      sat_r <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ma_r   <= ma_nxt;
    pr_r   <= pr_nxt;
    neg_r  <= neg_nxt;
    dv_r   <= dv_nxt;
    rm_r   <= rm_nxt;
    nq_r   <= nq_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
    srn_r  <= srn_nxt;
    ocx_r  <= ocx_nxt;
    ocy_r  <= ocy_nxt;
    orad_r <= orad_nxt;
    ost_r  <= ost_nxt;
    if (st_r == S_FETCH) begin
      opa_r <= (uop.sa == RI_ZERO) ? '0 : rf_r[uop.sa[RIW-1:0]];
      opb_r <= (uop.sb == RI_ZERO) ? '0 : rf_r[uop.sb[RIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NIN; i++) begin
        rf_r[i] <= sys_i[i*W +: W];
      end
    end else if (rf_we) begin
      rf_r[rf_wi[RIW-1:0]] <= rf_wd;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/circle_from_3x3_linear_solve.sv
// Top level of the circle fit by Gaussian elimination on a 3x3 linear system.
//
// Usage: the input channel is a queue. A word (nine matrix entries and three
// right-hand entries, signed fixed point with FRAC_BITS fraction bits) is
// taken at a rising edge with in_push high and in_full low. The result
// channel is a queue too: while out_empty is low the oldest result sits on
// the out_ ports and is taken at an edge with out_pop high.
// A two-word queue holds systems while the back end works, so the sender is
// not held up by a result that waits to be popped until the queue is full.
// The back end runs a fixed list of 37 steps through one shared bit-serial
// multiplier, one restoring divider and one digit-serial square root. A zero
// leading pivot, flagged in the input queue, is answered without running the
// steps. The back end takes up a new system only once the previous result
// has been popped, since the shared arithmetic units serve one system at a
// time.
// When out_pop stays low the finished result is held and the back end
// waits; the input queue keeps taking words until it is full.
// Reset (synchronous, active low) empties both sides and drops work in hand.
`default_nettype none
module circle_from_3x3_linear_solve
  import cf3_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic signed [DATA_WIDTH-1:0]  in_m00,
  input  wire logic signed [DATA_WIDTH-1:0]  in_m01,
  input  wire logic signed [DATA_WIDTH-1:0]  in_m02,
  input  wire logic signed [DATA_WIDTH-1:0]  in_m10,
  input  wire logic signed [DATA_WIDTH-1:0]  in_m11,
  input  wire logic signed [DATA_WIDTH-1:0]  in_m12,
  input  wire logic signed [DATA_WIDTH-1:0]  in_m20,
  input  wire logic signed [DATA_WIDTH-1:0]  in_m21,
  input  wire logic signed [DATA_WIDTH-1:0]  in_m22,
  input  wire logic signed [DATA_WIDTH-1:0]  in_r0,
  input  wire logic signed [DATA_WIDTH-1:0]  in_r1,
  input  wire logic signed [DATA_WIDTH-1:0]  in_r2,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic signed [DATA_WIDTH-1:0]       out_center_x,
  output logic signed [DATA_WIDTH-1:0]       out_center_y,
  output logic [DATA_WIDTH-2:0]              out_radius,
  output logic [1:0]                         out_status
);

  logic [NIN*DATA_WIDTH-1:0] sys_in, sys_q;
  cf3_hs_t                   hs;
  logic                      take;

  // Matrix entry m00 sits in the lowest slot, the right-hand r2 in the highest,
  // matching the working register order of the back end.
  assign sys_in = {in_r2, in_r1, in_r0, in_m22, in_m21, in_m20,
                   in_m12, in_m11, in_m10, in_m02, in_m01, in_m00};

  cf3_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .sys_i (sys_in),
    .hs_o  (hs),
    .sys_o (sys_q),
    .take  (take)
  );

  cf3_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .hs_i     (hs),
    .sys_i    (sys_q),
    .take     (take),
    .empty    (out_empty),
    .pop      (out_pop),
    .center_x (out_center_x),
    .center_y (out_center_y),
    .radius   (out_radius),
    .status   (out_status)
  );

`ifndef NO_ASSERTIONS
  // A zero pivot reports an all-zero circle.
  a_pivot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == ST_PIVOT) |->
      (out_center_x == '0 && out_center_y == '0 && out_radius == '0))
    else $error("zero pivot result carries nonzero fields");

  // A negative radicand reports a zero radius.
  a_neg_radius: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == ST_NEG) |-> (out_radius == '0))
    else $error("negative radicand result carries nonzero radius");

  // The back end cannot have a new result ready in the cycle after a pop.
  a_pop_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty) |=> out_empty)
    else $error("result reappeared directly after pop");
`endif

endmodule
`default_nettype wire
